FILE: hdl/tss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tss_pkg;

    localparam int NUM_SLOTS = 16;
    localparam int SLOT_W    = 4;
    localparam int CMD_W     = 2;
    localparam int STATUS_W  = 2;

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);

    typedef enum logic [1:0] {
        SLOT_FREE  = 2'd0,
        SLOT_RUN   = 2'd1,
        SLOT_READY = 2'd2,
        SLOT_WAIT  = 2'd3
    } t_slot_state;

    typedef enum logic [CMD_W-1:0] {
        CMD_CREATE = 2'd0,
        CMD_YIELD  = 2'd1,
        CMD_JOIN   = 2'd2,
        CMD_EXIT   = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        RES_OK      = 2'd0,
        RES_REJECT  = 2'd1,
        RES_BLOCKED = 2'd2,
        RES_HALTED  = 2'd3
    } t_res;

    typedef enum logic [1:0] {
        CTRL_IDLE,
        CTRL_GATHER,
        CTRL_APPLY,
        CTRL_FLUSH
    } t_ctrl_state;

    typedef struct packed {
        t_slot_state       state;
        logic [SLOT_W-1:0] parent;
        logic [SLOT_W-1:0] awaited;
    } t_entry;

    // Slot zero comes out of reset running, every other slot free.
    function automatic t_entry entry_init(input logic [SLOT_W-1:0] idx);
        t_entry e;
        e.state   = (idx == '0) ? SLOT_RUN : SLOT_FREE;
        e.parent  = '0;
        e.awaited = '0;
        return e;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/tss_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface tss_cmd_if;
    logic                          valid;
    logic                          ready;
    logic [tss_pkg::CMD_W-1:0]     command;
    logic [tss_pkg::SLOT_W-1:0]    target_slot;

    modport source (output valid, output command, output target_slot, input ready);
    modport sink   (input valid, input command, input target_slot, output ready);
endinterface

interface tss_res_if;
    logic                          valid;
    logic                          ready;
    logic [tss_pkg::STATUS_W-1:0]  status;
    logic [tss_pkg::SLOT_W-1:0]    new_slot;
    logic [tss_pkg::SLOT_W-1:0]    running_slot;
    logic                          switched;

    modport source (output valid, output status, output new_slot, output running_slot,
                    output switched, input ready);
    modport sink   (input valid, input status, input new_slot, input running_slot,
                    input switched, output ready);
endinterface

`default_nettype wire

FILE: hdl/tss_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module tss_cell (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_shift,
    input  tss_pkg::t_entry  i_init,
    input  tss_pkg::t_entry  i_next,
    output tss_pkg::t_entry  o_entry
);

    tss_pkg::t_entry r_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry <= i_init;
        end else if (i_shift) begin
            r_entry <= i_next;
        end
    end

    assign o_entry = r_entry;

endmodule

`default_nettype wire

FILE: hdl/tss_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module tss_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    tss_cmd_if.sink          i_cmd,
    tss_res_if.source        o_res,
    input  tss_pkg::t_entry  i_head,
    output tss_pkg::t_entry  o_tail,
    output logic             o_shift
);

    localparam int SW = tss_pkg::SLOT_W;

    tss_pkg::t_ctrl_state r_state, n_state;

    logic [SW-1:0]          r_idx;
    tss_pkg::t_cmd          r_cmd;
    logic [SW-1:0]          r_tgt;
    logic [SW-1:0]          r_cur;
    logic                   r_halted;

    // Facts collected over the gather pass
    logic                   r_free_found;
    logic [SW-1:0]          r_free_idx;
    tss_pkg::t_slot_state   r_here_st;
    logic [SW-1:0]          r_tgt_parent;
    tss_pkg::t_slot_state   r_tgt_st;
    logic                   r_cand_found;
    logic [SW-1:0]          r_cand_idx;

    // Result waiting for the output register
    tss_pkg::t_res          r_pend_status;
    logic [SW-1:0]          r_pend_new;
    logic [SW-1:0]          r_pend_run;
    logic                   r_pend_sw;

    logic                   r_out_valid;
    tss_pkg::t_res          r_out_status;
    logic [SW-1:0]          r_out_new;
    logic [SW-1:0]          r_out_run;
    logic                   r_out_sw;

    logic                   cmd_beat;
    logic                   last_idx;
    logic                   out_free;
    logic                   join_reject;
    logic                   join_block;
    logic                   pick_en;
    tss_pkg::t_slot_state   here_mod;
    tss_pkg::t_slot_state   here_final;
    logic                   halt_now;
    logic [SW-1:0]          next_cur;
    tss_pkg::t_res          res_status;
    logic [SW-1:0]          res_new;
    logic                   res_sw;
    logic                   head_wakes;
    logic                   head_cand;

    assign cmd_beat = i_cmd.valid && i_cmd.ready;
    assign last_idx = (r_idx == tss_pkg::LAST_SLOT);
    assign out_free = !r_out_valid || o_res.ready;

    // Decisions follow from the gathered facts alone
    always_comb begin
        join_reject = ({1'b0, r_tgt} >= (SW + 1)'(tss_pkg::NUM_SLOTS))
                      || (r_tgt == r_cur) || (r_tgt_parent != r_cur);
        join_block  = !join_reject && (r_tgt_st != tss_pkg::SLOT_FREE);

        unique case (r_cmd)
            tss_pkg::CMD_CREATE: begin
                pick_en  = 1'b0;
                here_mod = r_here_st;
            end
            tss_pkg::CMD_YIELD: begin
                pick_en  = 1'b1;
                here_mod = (r_here_st == tss_pkg::SLOT_RUN) ? tss_pkg::SLOT_READY : r_here_st;
            end
            tss_pkg::CMD_JOIN: begin
                pick_en  = join_block;
                here_mod = join_block ? tss_pkg::SLOT_WAIT : r_here_st;
            end
            tss_pkg::CMD_EXIT: begin
                pick_en  = 1'b1;
                here_mod = tss_pkg::SLOT_FREE;
            end
            default: begin
                pick_en  = 1'b0;
                here_mod = r_here_st;
            end
        endcase

        priority if (r_cand_found) begin
            here_final = (here_mod == tss_pkg::SLOT_RUN) ? tss_pkg::SLOT_READY : here_mod;
        end else if (here_mod == tss_pkg::SLOT_READY) begin
            here_final = tss_pkg::SLOT_RUN;
        end else begin
            here_final = here_mod;
        end

        halt_now = pick_en && !r_cand_found && (here_mod != tss_pkg::SLOT_READY);
        res_sw   = pick_en && r_cand_found;
        next_cur = res_sw ? r_cand_idx : r_cur;
        res_new  = ((r_cmd == tss_pkg::CMD_CREATE) && r_free_found) ? r_free_idx : '0;

        priority if ((r_cmd == tss_pkg::CMD_CREATE) && !r_free_found) begin
            res_status = tss_pkg::RES_REJECT;
        end else if ((r_cmd == tss_pkg::CMD_JOIN) && join_reject) begin
            res_status = tss_pkg::RES_REJECT;
        end else if (halt_now) begin
            res_status = tss_pkg::RES_HALTED;
        end else if ((r_cmd == tss_pkg::CMD_JOIN) && join_block) begin
            res_status = tss_pkg::RES_BLOCKED;
        end else begin
            res_status = tss_pkg::RES_OK;
        end
    end

    // A waiter on the exiting slot is runnable again
    assign head_wakes = (r_cmd == tss_pkg::CMD_EXIT) && (r_idx != r_cur)
                        && (i_head.state == tss_pkg::SLOT_WAIT) && (i_head.awaited == r_cur);
    assign head_cand  = (r_idx != r_cur)
                        && ((i_head.state == tss_pkg::SLOT_READY) || head_wakes);

    // Write-back of the slot passing the head on the apply pass
    always_comb begin
        o_tail = i_head;
        if (r_state == tss_pkg::CTRL_APPLY) begin
            if ((r_cmd == tss_pkg::CMD_CREATE) && r_free_found && (r_idx == r_free_idx)) begin
                o_tail.state  = tss_pkg::SLOT_READY;
                o_tail.parent = r_cur;
            end
            if (head_wakes) begin
                o_tail.state = tss_pkg::SLOT_READY;
            end
            if (pick_en && (r_idx == r_cur)) begin
                o_tail.state = here_final;
                if (r_cmd == tss_pkg::CMD_JOIN) begin
                    o_tail.awaited = r_tgt;
                end
            end
            if (res_sw && (r_idx == r_cand_idx)) begin
                o_tail.state = tss_pkg::SLOT_RUN;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tss_pkg::CTRL_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_shift     = 1'b0;
        i_cmd.ready = 1'b0;
        unique case (r_state)
            tss_pkg::CTRL_IDLE: begin
                i_cmd.ready = 1'b1;
                if (i_cmd.valid) begin
                    n_state = r_halted ? tss_pkg::CTRL_FLUSH : tss_pkg::CTRL_GATHER;
                end
            end
            tss_pkg::CTRL_GATHER: begin
                o_shift = 1'b1;
                if (last_idx) begin
                    n_state = tss_pkg::CTRL_APPLY;
                end
            end
            tss_pkg::CTRL_APPLY: begin
                o_shift = 1'b1;
                if (last_idx) begin
                    n_state = tss_pkg::CTRL_FLUSH;
                end
            end
            tss_pkg::CTRL_FLUSH: begin
                if (out_free) begin
                    n_state = tss_pkg::CTRL_IDLE;
                end
            end
            default: n_state = tss_pkg::CTRL_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_cur       <= '0;
            r_halted    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_shift) begin
                r_idx <= last_idx ? '0 : r_idx + 1'b1;
            end
            if ((r_state == tss_pkg::CTRL_APPLY) && last_idx) begin
                r_cur    <= next_cur;
                r_halted <= halt_now;
            end
            if ((r_state == tss_pkg::CTRL_FLUSH) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (cmd_beat) begin
            r_cmd         <= tss_pkg::t_cmd'(i_cmd.command);
            r_tgt         <= i_cmd.target_slot;
            r_free_found  <= 1'b0;
            r_cand_found  <= 1'b0;
            r_free_idx    <= '0;
            r_cand_idx    <= '0;
            r_here_st     <= tss_pkg::SLOT_FREE;
            r_tgt_parent  <= '0;
            r_tgt_st      <= tss_pkg::SLOT_FREE;
            r_pend_status <= tss_pkg::RES_HALTED;
            r_pend_new    <= '0;
            r_pend_run    <= r_cur;
            r_pend_sw     <= 1'b0;
        end
        if (r_state == tss_pkg::CTRL_GATHER) begin
            if (!r_free_found && (i_head.state == tss_pkg::SLOT_FREE)) begin
                r_free_found <= 1'b1;
                r_free_idx   <= r_idx;
            end
            if (r_idx == r_cur) begin
                r_here_st <= i_head.state;
            end
            if (r_idx == r_tgt) begin
                r_tgt_parent <= i_head.parent;
                r_tgt_st     <= i_head.state;
            end
            if (!r_cand_found && head_cand) begin
                r_cand_found <= 1'b1;
                r_cand_idx   <= r_idx;
            end
        end
        if ((r_state == tss_pkg::CTRL_APPLY) && last_idx) begin
            r_pend_status <= res_status;
            r_pend_new    <= res_new;
            r_pend_run    <= next_cur;
            r_pend_sw     <= res_sw;
        end
        if ((r_state == tss_pkg::CTRL_FLUSH) && out_free) begin
            r_out_status <= r_pend_status;
            r_out_new    <= r_pend_new;
            r_out_run    <= r_pend_run;
            r_out_sw     <= r_pend_sw;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.status       = r_out_status;
    assign o_res.new_slot     = r_out_new;
    assign o_res.running_slot = r_out_run;
    assign o_res.switched     = r_out_sw;

endmodule

`default_nettype wire

FILE: hdl/thread_slot_scheduler.sv
`timescale 1ns / 1ps
`default_nettype none
// Thread slot table with a first-runnable scheduler.
// i_cmd carries one command per beat (create, yield, join target_slot, exit);
// o_res returns exactly one result beat per command: status, new_slot,
// running_slot and switched.
// The slot table lives in a ring of NUM_SLOTS cells that rotates one place a
// cycle while a command runs; the controller sees each slot as it passes
// the head. A command takes two full turns of the ring: a gather turn that
// finds the free slot, the target and the next runnable slot, and an apply
// turn that writes the new states back. The result is registered after the
// apply turn, and i_cmd is ready again in the same cycle that the result
// turns valid; no new command is taken while one is still in the ring.
// Once halted the ring stays still: each command goes from idle straight to
// the flush state, which loads its result, with no gather or apply turn.
// Reset: slot 0 running, all other slots free, not halted, no result pending.
// A stalled result is held in the output register; a finished command waits
// for it to drain before its own result loads, and i_cmd is not ready
// until then.
module thread_slot_scheduler (
    input  wire        i_clk,
    input  wire        i_rst_n,
    tss_cmd_if.sink    i_cmd,
    tss_res_if.source  o_res
);

    localparam int N = tss_pkg::NUM_SLOTS;

    tss_pkg::t_entry w_entry [N];
    tss_pkg::t_entry w_tail;
    logic            w_shift;

    tss_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (i_cmd),
        .o_res   (o_res),
        .i_head  (w_entry[0]),
        .o_tail  (w_tail),
        .o_shift (w_shift)
    );

    for (genvar i = 0; i < N; i++) begin : g_cell
        tss_pkg::t_entry w_next;
        if (i == N - 1) begin : g_last
            assign w_next = w_tail;
        end else begin : g_mid
            assign w_next = w_entry[i + 1];
        end
        tss_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (w_shift),
            .i_init  (tss_pkg::entry_init(tss_pkg::SLOT_W'(i))),
            .i_next  (w_next),
            .o_entry (w_entry[i])
        );
    end

endmodule

`default_nettype wire

FILE: hdl/tss_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module tss_checker (
    input wire                              i_clk,
    input wire                              i_rst_n,
    input wire                              i_res_valid,
    input wire                              i_res_ready,
    input wire [tss_pkg::STATUS_W-1:0]      i_res_status,
    input wire [tss_pkg::SLOT_W-1:0]        i_res_new,
    input wire                              i_res_switched
);

    // Hold a stalled result
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid)
        else $error("result dropped while stalled");

    // A blocked caller always hands over to another thread
    a_block_switch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && (i_res_status == tss_pkg::RES_BLOCKED) |-> i_res_switched)
        else $error("blocked without a switch");

    a_halt_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && (i_res_status == tss_pkg::RES_HALTED)
        |-> !i_res_switched && (i_res_new == '0))
        else $error("halted result carries a switch or new slot");

    // A created slot never comes with a reschedule
    a_create_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && (i_res_new != '0)
        |-> (i_res_status == tss_pkg::RES_OK) && !i_res_switched)
        else $error("new slot with bad status or switch");

endmodule

bind thread_slot_scheduler tss_checker u_tss_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_res_valid    (o_res.valid),
    .i_res_ready    (o_res.ready),
    .i_res_status   (o_res.status),
    .i_res_new      (o_res.new_slot),
    .i_res_switched (o_res.switched)
);

`default_nettype wire

FILE: sim/tb_thread_slot_scheduler.sv
`timescale 1ns / 1ps

module tb_thread_slot_scheduler;

    localparam int RANDOM_ITEMS   = 2000;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PRESSURE_AT    = 600;
    localparam int PRESSURE_LEN   = 400;

    typedef struct packed {
        tss_pkg::t_res                 status;
        logic [tss_pkg::SLOT_W-1:0]    new_slot;
        logic [tss_pkg::SLOT_W-1:0]    running_slot;
        logic                          switched;
    } t_sched_result;

    class t_sched_scoreboard;
        tss_pkg::t_slot_state          state   [tss_pkg::NUM_SLOTS];
        logic [tss_pkg::SLOT_W-1:0]    parent  [tss_pkg::NUM_SLOTS];
        logic [tss_pkg::SLOT_W-1:0]    awaited [tss_pkg::NUM_SLOTS];
        logic [tss_pkg::SLOT_W-1:0]    here;
        bit                            halted;
        t_sched_result                 pending_results[$];
        int n_errors, n_commands, n_checked;
        int n_created, n_rejected, n_blocked, n_switched, n_halted;

        function new();
            foreach (state[s]) begin
                state[s]   = (s == 0) ? tss_pkg::SLOT_RUN : tss_pkg::SLOT_FREE;
                parent[s]  = '0;
                awaited[s] = '0;
            end
            here   = '0;
            halted = 1'b0;
        endfunction

        // Lowest runnable slot other than the current one, else the current one if ready, else halt.
        function bit reschedule(output bit moved);
            moved = 1'b0;
            for (int s = 0; s < tss_pkg::NUM_SLOTS; s++) begin
                if (state[s] == tss_pkg::SLOT_READY && s != here) begin
                    if (state[here] == tss_pkg::SLOT_RUN)
                        state[here] = tss_pkg::SLOT_READY;
                    state[s] = tss_pkg::SLOT_RUN;
                    here     = tss_pkg::SLOT_W'(s);
                    moved    = 1'b1;
                    return 1'b0;
                end
            end
            if (state[here] == tss_pkg::SLOT_READY) begin
                state[here] = tss_pkg::SLOT_RUN;
                return 1'b0;
            end
            halted = 1'b1;
            return 1'b1;
        endfunction

        function bit exit_halts();
            foreach (state[s])
                if (s != here && (state[s] == tss_pkg::SLOT_READY ||
                                  (state[s] == tss_pkg::SLOT_WAIT &&
                                   awaited[s] == here)))
                    return 1'b0;
            return 1'b1;
        endfunction

        function bit join_halts(logic [tss_pkg::SLOT_W-1:0] t);
            if (t == here || parent[t] != here || state[t] == tss_pkg::SLOT_FREE)
                return 1'b0;
            foreach (state[s])
                if (state[s] == tss_pkg::SLOT_READY)
                    return 1'b0;
            return 1'b1;
        endfunction

        function void note_command(tss_pkg::t_cmd c, logic [tss_pkg::SLOT_W-1:0] t);
            t_sched_result r;
            int            s;
            bit            moved;
            r.status   = tss_pkg::RES_OK;
            r.new_slot = '0;
            moved      = 1'b0;
            n_commands++;
            if (halted) begin
                r.status = tss_pkg::RES_HALTED;
            end else begin
                case (c)
                    tss_pkg::CMD_CREATE: begin
                        for (s = 0; s < tss_pkg::NUM_SLOTS; s++)
                            if (state[s] == tss_pkg::SLOT_FREE)
                                break;
                        if (s >= tss_pkg::NUM_SLOTS) begin
                            r.status = tss_pkg::RES_REJECT;
                        end else begin
                            parent[s]  = here;
                            state[s]   = tss_pkg::SLOT_READY;
                            r.new_slot = tss_pkg::SLOT_W'(s);
                        end
                    end
                    tss_pkg::CMD_YIELD: begin
                        if (state[here] == tss_pkg::SLOT_RUN)
                            state[here] = tss_pkg::SLOT_READY;
                        if (reschedule(moved))
                            r.status = tss_pkg::RES_HALTED;
                    end
                    tss_pkg::CMD_JOIN: begin
                        if (int'(t) >= tss_pkg::NUM_SLOTS || t == here
                            || parent[t] != here) begin
                            r.status = tss_pkg::RES_REJECT;
                        end else if (state[t] != tss_pkg::SLOT_FREE) begin
                            state[here]   = tss_pkg::SLOT_WAIT;
                            awaited[here] = t;
                            r.status = reschedule(moved) ? tss_pkg::RES_HALTED
                                                         : tss_pkg::RES_BLOCKED;
                        end
                    end
                    default: begin
                        state[here] = tss_pkg::SLOT_FREE;
                        // wake every joiner of the exiting slot
                        foreach (state[w])
                            if (state[w] == tss_pkg::SLOT_WAIT && awaited[w] == here)
                                state[w] = tss_pkg::SLOT_READY;
                        if (reschedule(moved))
                            r.status = tss_pkg::RES_HALTED;
                    end
                endcase
            end
            r.running_slot = here;
            r.switched     = moved;
            if (r.status == tss_pkg::RES_OK && c == tss_pkg::CMD_CREATE && !halted)
                n_created++;
            if (r.status == tss_pkg::RES_REJECT)  n_rejected++;
            if (r.status == tss_pkg::RES_BLOCKED) n_blocked++;
            if (r.status == tss_pkg::RES_HALTED)  n_halted++;
            if (moved)                            n_switched++;
            pending_results.push_back(r);
        endfunction

        task report(string what);
            $display("[%0t] MISMATCH beat %0d: %s", $time, n_checked, what);
            n_errors++;
        endtask

        task check_result(t_sched_result got);
            t_sched_result want;
            if (pending_results.size() == 0) begin
                report("result beat with no command outstanding");
                return;
            end
            want = pending_results.pop_front();
            n_checked++;
            if (got.status !== want.status)
                report($sformatf("status got %0d want %0d", got.status, want.status));
            if (got.new_slot !== want.new_slot)
                report($sformatf("new_slot got %0d want %0d", got.new_slot, want.new_slot));
            if (got.running_slot !== want.running_slot)
                report($sformatf("running_slot got %0d want %0d",
                                 got.running_slot, want.running_slot));
            if (got.switched !== want.switched)
                report($sformatf("switched got %0b want %0b", got.switched, want.switched));
        endtask

        task report_leftovers();
            if (pending_results.size() != 0)
                report($sformatf("%0d result beats never arrived", pending_results.size()));
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    bit   calm;
    int   quiet_cycles;

    t_sched_scoreboard sched;
    t_sched_result     seen_result;

    tss_cmd_if cmd_if ();
    tss_res_if res_if ();

    thread_slot_scheduler dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_res   (res_if)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic int idle_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    task automatic send_cmd(input tss_pkg::t_cmd c,
                            input logic [tss_pkg::SLOT_W-1:0] t);
        int gap;
        gap = idle_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        cmd_if.valid       <= 1'b1;
        cmd_if.command     <= c;
        cmd_if.target_slot <= t;
        do @(posedge i_clk); while (!cmd_if.ready);
        sched.note_command(c, t);
    endtask

    // Mostly children of the running slot as join targets; steer clear of a halt.
    task automatic pick_command(output tss_pkg::t_cmd c,
                                output logic [tss_pkg::SLOT_W-1:0] t);
        int r;
        int kids[$];
        t = tss_pkg::SLOT_W'($urandom_range(0, tss_pkg::NUM_SLOTS - 1));
        r = $urandom_range(0, 99);
        if (r < 30) begin
            c = tss_pkg::CMD_CREATE;
        end else if (r < 50) begin
            c = tss_pkg::CMD_YIELD;
        end else if (r < 78) begin
            c = tss_pkg::CMD_JOIN;
            foreach (sched.parent[s])
                if (sched.parent[s] == sched.here && s != sched.here)
                    kids.push_back(s);
            if (kids.size() > 0 && $urandom_range(0, 3) != 0)
                t = tss_pkg::SLOT_W'(kids[$urandom_range(0, kids.size() - 1)]);
        end else begin
            c = tss_pkg::CMD_EXIT;
        end
        if ((c == tss_pkg::CMD_EXIT && sched.exit_halts())
            || (c == tss_pkg::CMD_JOIN && sched.join_halts(t)))
            c = tss_pkg::CMD_YIELD;
    endtask

    initial begin
        tss_pkg::t_cmd              c;
        logic [tss_pkg::SLOT_W-1:0] t;
        int                         waited;
        sched              = new();
        calm               = 1'b0;
        i_rst_n            = 1'b0;
        cmd_if.valid       = 1'b0;
        cmd_if.command     = tss_pkg::CMD_CREATE;
        cmd_if.target_slot = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_cmd(tss_pkg::CMD_JOIN, 4'd0);      // join of itself
        send_cmd(tss_pkg::CMD_JOIN, 4'd15);     // never-created slot counts as a free child
        send_cmd(tss_pkg::CMD_YIELD, 4'd0);     // lone thread keeps running
        send_cmd(tss_pkg::CMD_CREATE, 4'd0);
        send_cmd(tss_pkg::CMD_JOIN, 4'd1);      // busy child: caller blocks
        send_cmd(tss_pkg::CMD_JOIN, 4'd0);      // not a child
        send_cmd(tss_pkg::CMD_CREATE, 4'd0);
        send_cmd(tss_pkg::CMD_YIELD, 4'd15);
        send_cmd(tss_pkg::CMD_EXIT, 4'd0);
        send_cmd(tss_pkg::CMD_EXIT, 4'd0);      // wakes the waiting parent
        // fill, then one too many
        repeat (tss_pkg::NUM_SLOTS) send_cmd(tss_pkg::CMD_CREATE, 4'd0);

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            calm = (i >= 800 && i < 1000);
            pick_command(c, t);
            send_cmd(c, t);
        end
        calm = 1'b0;

        // Drain the table until the block halts, then poke it once more per command.
        for (int i = 0; i < 2 * tss_pkg::NUM_SLOTS && !sched.halted; i++)
            send_cmd(tss_pkg::CMD_EXIT,
                     tss_pkg::SLOT_W'($urandom_range(0, tss_pkg::NUM_SLOTS - 1)));
        send_cmd(tss_pkg::CMD_CREATE, 4'd0);
        send_cmd(tss_pkg::CMD_YIELD, 4'd15);
        send_cmd(tss_pkg::CMD_JOIN, 4'd15);
        send_cmd(tss_pkg::CMD_EXIT, 4'd0);
        @(negedge i_clk);
        cmd_if.valid <= 1'b0;

        waited = 0;
        while (sched.pending_results.size() != 0 && waited < 10 * WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (2 * tss_pkg::NUM_SLOTS + 8) @(posedge i_clk);
        sched.report_leftovers();

        $display("Covered %0d commands, %0d results: %0d creates, %0d rejects, %0d blocked joins",
                 sched.n_commands, sched.n_checked, sched.n_created, sched.n_rejected,
                 sched.n_blocked);
        $display("  %0d thread switches, %0d halted replies, one long output stall",
                 sched.n_switched, sched.n_halted);
        if (sched.n_errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Result side: random stalls, plus one long hold-off to back the block up.
    initial begin
        int stall;
        bit pressure_done;
        stall         = 0;
        pressure_done = 1'b0;
        res_if.ready  = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!pressure_done && sched.n_checked >= PRESSURE_AT) begin
                pressure_done = 1'b1;
                stall         = PRESSURE_LEN;
            end else if (stall == 0 && $urandom_range(0, 3) == 0) begin
                stall = idle_gap();
            end
            if (stall > 0) begin
                res_if.ready <= 1'b0;
                stall--;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            seen_result.status       = tss_pkg::t_res'(res_if.status);
            seen_result.new_slot     = res_if.new_slot;
            seen_result.running_slot = res_if.running_slot;
            seen_result.switched     = res_if.switched;
            sched.check_result(seen_result);
        end
    end

    // Abort when no beat moves on either side for too long.
    always @(posedge i_clk) begin
        if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)) begin
            quiet_cycles = 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[%0t] timeout: no beat for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("Mismatches found");
            $finish;
        end else begin
            quiet_cycles = quiet_cycles + 1;
        end
    end

endmodule
